// ===== hdl/ddodo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddodo_pkg
// Types, constants and helper functions shared by the odometry block.
// ----------------------------------------------------------------------------
package ddodo_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int QUEUE_DEPTH  = 2;
    localparam int DIV_BITS     = 80;

    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] CORDIC_K    = 36'sd652032874;
    localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
    localparam logic signed [51:0] TWO_PI_Q28  = 52'sd1686629713;
    localparam logic [29:0]        NS_PER_S    = 30'd1000000000;

    localparam logic [31:0] LINEAR_GAIN_RESET  = 32'd13421773;
    localparam logic [31:0] ANGULAR_GAIN_RESET = 32'd59652324;

    localparam logic REG_LINEAR_GAIN  = 1'b0;
    localparam logic REG_ANGULAR_GAIN = 1'b1;

    typedef struct packed {
        logic signed [32:0] sum;
        logic signed [32:0] dif;
        logic [62:0]        dt;
        logic               dt_pos;
    } t_job;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] lin_speed;
        logic signed [31:0] ang_speed;
        logic               speed_valid;
    } t_result;

    typedef enum logic [4:0] {
        BK_IDLE, BK_MUL_DS, BK_MUL_DTH, BK_HEAD, BK_ROT_START, BK_ROT_WAIT,
        BK_MX_LO, BK_MX_HI, BK_MY_LO, BK_MY_HI, BK_QUAT_START, BK_QUAT_WAIT,
        BK_LIN_START, BK_LIN_WAIT, BK_ANG_START, BK_ANG_WAIT, BK_DONE
    } t_back_state;

    typedef enum logic [1:0] {RT_IDLE, RT_RUN, RT_DONE} t_rot_state;

    typedef enum logic [2:0] {DV_IDLE, DV_MUL_LO, DV_MUL_HI, DV_RUN, DV_DONE} t_div_state;

    function automatic logic signed [35:0] f_atan(input logic [4:0] i);
        logic signed [35:0] r;
        case (i)
            5'd0:    r = 36'sd843314857;
            5'd1:    r = 36'sd497837829;
            5'd2:    r = 36'sd263043837;
            5'd3:    r = 36'sd133525159;
            5'd4:    r = 36'sd67021687;
            5'd5:    r = 36'sd33543516;
            5'd6:    r = 36'sd16775851;
            5'd7:    r = 36'sd8388437;
            5'd8:    r = 36'sd4194283;
            5'd9:    r = 36'sd2097149;
            5'd10:   r = 36'sd1048576;
            5'd31:   r = '0;
            default: r = 36'sd1 <<< (5'd30 - i);
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -42'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] f_clamp_unit(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q30) begin
            r = ONE_Q30[31:0];
        end else if (v < -ONE_Q30) begin
            r = 32'(-ONE_Q30);
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/ddodo_if.sv =====
// ----------------------------------------------------------------------------
// ddodo_in_if / ddodo_out_if
// Valid/ready channels for wheel samples and pose results.
// ----------------------------------------------------------------------------
interface ddodo_in_if;
    logic               valid;
    logic               ready;
    logic [62:0]        stamp_ns;
    logic signed [31:0] left_wheel_angle;
    logic signed [31:0] right_wheel_angle;

    modport source (output valid, output stamp_ns, output left_wheel_angle,
                    output right_wheel_angle, input ready);
    modport sink (input valid, input stamp_ns, input left_wheel_angle,
                  input right_wheel_angle, output ready);
endinterface

interface ddodo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] lin_speed;
    logic signed [31:0] ang_speed;
    logic               speed_valid;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    output quat_z, output quat_w, output lin_speed, output ang_speed,
                    output speed_valid, input ready);
    modport sink (input valid, input pos_x, input pos_y, input heading,
                  input quat_z, input quat_w, input lin_speed, input ang_speed,
                  input speed_valid, output ready);
endinterface

// ===== hdl/ddodo_front.sv =====
// ----------------------------------------------------------------------------
// ddodo_front
// Accepts samples, forms wheel deltas and the time step, and queues a job.
// ----------------------------------------------------------------------------
module ddodo_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ddodo_in_if.sink       i_in,
    input  logic           i_full,
    output logic           o_push,
    output ddodo_pkg::t_job o_job
);
    import ddodo_pkg::*;

    logic [62:0]        r_prev_stamp;
    logic [31:0]        r_prev_left;
    logic [31:0]        r_prev_right;
    logic signed [31:0] dl;
    logic signed [31:0] dr;
    logic [63:0]        dt_full;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        dl            = i_in.left_wheel_angle - r_prev_left;
        dr            = i_in.right_wheel_angle - r_prev_right;
        dt_full       = {1'b0, i_in.stamp_ns} - {1'b0, r_prev_stamp};
        o_job.sum     = {dr[31], dr} + {dl[31], dl};
        o_job.dif     = {dr[31], dr} - {dl[31], dl};
        o_job.dt      = dt_full[62:0];
        o_job.dt_pos  = !dt_full[63] && (dt_full != 64'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_stamp <= '0;
            r_prev_left  <= '0;
            r_prev_right <= '0;
        end else if (o_push) begin
            r_prev_stamp <= i_in.stamp_ns;
            r_prev_left  <= i_in.left_wheel_angle;
            r_prev_right <= i_in.right_wheel_angle;
        end
    end

endmodule

// ===== hdl/ddodo_fifo.sv =====
// ----------------------------------------------------------------------------
// ddodo_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ddodo_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ddodo_pkg::t_job i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output ddodo_pkg::t_job o_data
);
    import ddodo_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    t_job        r_mem [QUEUE_DEPTH];
    logic [QW-1:0] r_wr;
    logic [QW-1:0] r_rd;
    logic [QW:0]   r_count;

    assign o_full  = (r_count == (QW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (QW+1)'(i_push) - (QW+1)'(i_pop);
        end
    end

endmodule

// ===== hdl/ddodo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddodo_cordic
// Iterative CORDIC giving cosine and sine of a Q.30 angle, one step a cycle.
// ----------------------------------------------------------------------------
module ddodo_cordic (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [35:0]      i_angle,
    output logic                    o_done,
    output logic signed [35:0]      o_cos,
    output logic signed [35:0]      o_sin
);
    import ddodo_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);

    t_rot_state         r_state;
    t_rot_state         n_state;
    logic signed [35:0] r_x;
    logic signed [35:0] r_y;
    logic signed [35:0] r_a;
    logic               r_flip;
    logic [IW-1:0]      r_i;
    logic signed [35:0] a1;
    logic signed [35:0] a2;
    logic               flip;
    logic signed [35:0] xs;
    logic signed [35:0] ys;

    always_comb begin
        if (i_angle > PI_Q30) begin
            a1 = i_angle - TWO_PI_Q30;
        end else if (i_angle < -PI_Q30) begin
            a1 = i_angle + TWO_PI_Q30;
        end else begin
            a1 = i_angle;
        end
        flip = 1'b1;
        if (a1 > HALF_PI_Q30) begin
            a2 = a1 - PI_Q30;
        end else if (a1 < -HALF_PI_Q30) begin
            a2 = a1 + PI_Q30;
        end else begin
            a2   = a1;
            flip = 1'b0;
        end
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            RT_IDLE: if (i_start) n_state = RT_RUN;
            RT_RUN:  if (r_i == IW'(CORDIC_STEPS - 1)) n_state = RT_DONE;
            RT_DONE: n_state = RT_IDLE;
            default: n_state = RT_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == RT_DONE);
        o_cos  = r_flip ? -r_x : r_x;
        o_sin  = r_flip ? -r_y : r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            RT_IDLE: begin
                if (i_start) begin
                    r_x    <= CORDIC_K;
                    r_y    <= '0;
                    r_a    <= a2;
                    r_flip <= flip;
                    r_i    <= '0;
                end
            end
            RT_RUN: begin
                if (!r_a[35]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_a <= r_a - f_atan(5'(r_i));
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_a <= r_a + f_atan(5'(r_i));
                end
                r_i <= r_i + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/ddodo_div.sv =====
// ----------------------------------------------------------------------------
// ddodo_div
// Speed divider: magnitude times 1e9 over dt, one quotient bit a cycle,
// saturated and scaled to a signed 32-bit result.
// ----------------------------------------------------------------------------
module ddodo_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [49:0]        i_mag,
    input  logic               i_neg,
    input  logic [62:0]        i_dt,
    input  logic               i_scale,
    output logic               o_done,
    output logic signed [31:0] o_q
);
    import ddodo_pkg::*;

    localparam int CW = $clog2(DIV_BITS);

    t_div_state       r_state;
    t_div_state       n_state;
    logic [49:0]      r_mag;
    logic             r_neg;
    logic [62:0]      r_dt;
    logic             r_scale;
    logic [DIV_BITS-1:0] r_num;
    logic [62:0]      r_rem;
    logic [45:0]      r_q;
    logic [CW-1:0]    r_cnt;
    logic [63:0]      rem_sh;
    logic             ge;
    logic [63:0]      rem_nx;
    logic [45:0]      q_sh;
    logic [45:0]      cap;
    logic [45:0]      q_out;
    logic [61:0]      p_lo;
    logic [47:0]      p_hi;

    always_comb begin
        p_lo   = r_mag[31:0] * NS_PER_S;
        p_hi   = r_mag[49:32] * NS_PER_S;
        rem_sh = {r_rem, r_num[DIV_BITS-1]};
        ge     = (rem_sh >= {1'b0, r_dt});
        rem_nx = ge ? rem_sh - {1'b0, r_dt} : rem_sh;
        q_sh   = {r_q[44:0], ge};
        cap    = r_scale ? (46'd1 << 44) : (46'd1 << 32);
        q_out  = r_scale ? (r_q >> 12) : r_q;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            DV_IDLE:   if (i_start) n_state = DV_MUL_LO;
            DV_MUL_LO: n_state = DV_MUL_HI;
            DV_MUL_HI: n_state = DV_RUN;
            DV_RUN:    if (r_cnt == CW'(DIV_BITS - 1)) n_state = DV_DONE;
            DV_DONE:   n_state = DV_IDLE;
            default:   n_state = DV_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == DV_DONE);
        if (r_neg) begin
            o_q = (q_out >= 46'd2147483648) ? 32'sh80000000 : -$signed(q_out[31:0]);
        end else begin
            o_q = (q_out >= 46'd2147483647) ? 32'sh7FFFFFFF : $signed(q_out[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    r_mag   <= i_mag;
                    r_neg   <= i_neg;
                    r_dt    <= i_dt;
                    r_scale <= i_scale;
                end
            end
            DV_MUL_LO: begin
                r_num <= DIV_BITS'(p_lo);
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= '0;
            end
            DV_MUL_HI: begin
                r_num <= r_num + (DIV_BITS'(p_hi) << 32);
            end
            DV_RUN: begin
                r_num <= r_num << 1;
                r_rem <= rem_nx[62:0];
                r_q   <= (q_sh >= cap) ? cap : q_sh;
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/ddodo_back.sv =====
// ----------------------------------------------------------------------------
// ddodo_back
// Pose engine: gains, heading update, position and quaternion through the
// shared CORDIC, speeds through the divider, and the result register.
// ----------------------------------------------------------------------------
module ddodo_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  ddodo_pkg::t_job i_job,
    output logic            o_pop,
    input  logic [31:0]     i_linear_gain,
    input  logic [31:0]     i_angular_gain,
    ddodo_out_if.source     o_out
);
    import ddodo_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;
    t_job               r_job;
    t_result            r_out;
    logic               r_out_valid;
    logic [68:0]        r_acc;
    logic [36:0]        r_ds_mag;
    logic [48:0]        r_dth_mag;
    logic signed [31:0] r_heading;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [35:0] r_cos;
    logic signed [35:0] r_sin;
    logic signed [31:0] r_qz;
    logic signed [31:0] r_qw;
    logic signed [31:0] r_lin;
    logic signed [31:0] r_ang;

    logic [31:0]        m_a;
    logic [31:0]        m_b;
    logic [63:0]        m_p;
    logic [32:0]        sum_mag;
    logic [32:0]        dif_mag;
    logic [35:0]        cos_mag;
    logic [35:0]        sin_mag;
    logic signed [51:0] dth_s;
    logic signed [51:0] h0;
    logic signed [51:0] h1;
    logic signed [51:0] h2;
    logic signed [41:0] prod_s;
    logic signed [41:0] pos_sum_x;
    logic signed [41:0] pos_sum_y;
    logic               prod_neg_x;
    logic               prod_neg_y;
    logic               rot_start;
    logic signed [35:0] rot_angle;
    logic               rot_done;
    logic signed [35:0] rot_cos;
    logic signed [35:0] rot_sin;
    logic               div_start;
    logic [49:0]        div_mag;
    logic               div_neg;
    logic               div_scale;
    logic               div_done;
    logic signed [31:0] div_q;
    logic               can_load;

    ddodo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_angle (rot_angle),
        .o_done  (rot_done),
        .o_cos   (rot_cos),
        .o_sin   (rot_sin)
    );

    ddodo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (div_mag),
        .i_neg   (div_neg),
        .i_dt    (r_job.dt),
        .i_scale (div_scale),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    assign can_load = !r_out_valid || o_out.ready;

    always_comb begin
        sum_mag    = r_job.sum[32] ? 33'(-r_job.sum) : 33'(r_job.sum);
        dif_mag    = r_job.dif[32] ? 33'(-r_job.dif) : 33'(r_job.dif);
        cos_mag    = r_cos[35] ? 36'(-r_cos) : 36'(r_cos);
        sin_mag    = r_sin[35] ? 36'(-r_sin) : 36'(r_sin);
        dth_s      = $signed({3'b000, r_acc[64:16]});
        if (r_job.dif[32]) begin
            dth_s = -dth_s;
        end
        h0 = {{20{r_heading[31]}}, r_heading} + dth_s;
        if (h0 >= TWO_PI_Q28) begin
            h1 = h0 - TWO_PI_Q28;
        end else if (h0 <= -TWO_PI_Q28) begin
            h1 = h0 + TWO_PI_Q28;
        end else begin
            h1 = h0;
        end
        if (h1 >= TWO_PI_Q28) begin
            h2 = TWO_PI_Q28 - 52'sd1;
        end else if (h1 <= -TWO_PI_Q28) begin
            h2 = 52'sd1 - TWO_PI_Q28;
        end else begin
            h2 = h1;
        end
        prod_neg_x = r_job.sum[32] ^ r_cos[35];
        prod_neg_y = r_job.sum[32] ^ r_sin[35];
        prod_s     = $signed({3'b000, r_acc[68:30]});
        pos_sum_x  = {{10{r_x[31]}}, r_x} + (prod_neg_x ? -prod_s : prod_s);
        pos_sum_y  = {{10{r_y[31]}}, r_y} + (prod_neg_y ? -prod_s : prod_s);
        m_p        = m_a * m_b;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:       if (!i_empty) n_state = BK_MUL_DS;
            BK_MUL_DS:     n_state = BK_MUL_DTH;
            BK_MUL_DTH:    n_state = BK_HEAD;
            BK_HEAD:       n_state = BK_ROT_START;
            BK_ROT_START:  n_state = BK_ROT_WAIT;
            BK_ROT_WAIT:   if (rot_done) n_state = BK_MX_LO;
            BK_MX_LO:      n_state = BK_MX_HI;
            BK_MX_HI:      n_state = BK_MY_LO;
            BK_MY_LO:      n_state = BK_MY_HI;
            BK_MY_HI:      n_state = BK_QUAT_START;
            BK_QUAT_START: n_state = BK_QUAT_WAIT;
            BK_QUAT_WAIT: begin
                if (rot_done) begin
                    n_state = r_job.dt_pos ? BK_LIN_START : BK_DONE;
                end
            end
            BK_LIN_START:  n_state = BK_LIN_WAIT;
            BK_LIN_WAIT:   if (div_done) n_state = BK_ANG_START;
            BK_ANG_START:  n_state = BK_ANG_WAIT;
            BK_ANG_WAIT:   if (div_done) n_state = BK_DONE;
            BK_DONE:       if (can_load) n_state = BK_IDLE;
            default:       n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = (r_state == BK_IDLE) && !i_empty;
        rot_start = (r_state == BK_ROT_START) || (r_state == BK_QUAT_START);
        rot_angle = (r_state == BK_ROT_START) ? {{2{r_heading[31]}}, r_heading, 2'b00}
                                              : {{3{r_heading[31]}}, r_heading, 1'b0};
        div_start = (r_state == BK_LIN_START) || (r_state == BK_ANG_START);
        div_scale = (r_state == BK_ANG_START);
        div_mag   = div_scale ? 50'(r_dth_mag) : 50'(r_ds_mag);
        div_neg   = div_scale ? r_job.dif[32] : r_job.sum[32];
        m_a       = '0;
        m_b       = '0;
        case (r_state)
            BK_MUL_DS: begin
                m_a = sum_mag[31:0];
                m_b = i_linear_gain;
            end
            BK_MUL_DTH: begin
                m_a = dif_mag[31:0];
                m_b = i_angular_gain;
            end
            BK_MX_LO: begin
                m_a = r_ds_mag[31:0];
                m_b = cos_mag[31:0];
            end
            BK_MX_HI: begin
                m_a = 32'(r_ds_mag[36:32]);
                m_b = cos_mag[31:0];
            end
            BK_MY_LO: begin
                m_a = r_ds_mag[31:0];
                m_b = sin_mag[31:0];
            end
            BK_MY_HI: begin
                m_a = 32'(r_ds_mag[36:32]);
                m_b = sin_mag[31:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_heading   <= '0;
            r_x         <= '0;
            r_y         <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_DONE && can_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == BK_HEAD) begin
                r_heading <= h2[31:0];
            end
            if (r_state == BK_MY_LO) begin
                r_x <= f_sat32(pos_sum_x);
            end
            if (r_state == BK_QUAT_START) begin
                r_y <= f_sat32(pos_sum_y);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    r_job <= i_job;
                    r_lin <= '0;
                    r_ang <= '0;
                end
            end
            BK_MUL_DS: begin
                r_acc <= 69'(m_p) + (sum_mag[32] ? (69'(i_linear_gain) << 32) : 69'd0);
            end
            BK_MUL_DTH: begin
                r_ds_mag <= r_acc[64:28];
                r_acc    <= 69'(m_p) + (dif_mag[32] ? (69'(i_angular_gain) << 32) : 69'd0);
            end
            BK_HEAD: begin
                r_dth_mag <= r_acc[64:16];
            end
            BK_ROT_WAIT: begin
                if (rot_done) begin
                    r_cos <= rot_cos;
                    r_sin <= rot_sin;
                end
            end
            BK_MX_LO, BK_MY_LO: begin
                r_acc <= 69'(m_p);
            end
            BK_MX_HI, BK_MY_HI: begin
                r_acc <= r_acc + (69'(m_p) << 32);
            end
            BK_QUAT_WAIT: begin
                if (rot_done) begin
                    r_qz <= f_clamp_unit(rot_sin);
                    r_qw <= f_clamp_unit(rot_cos);
                end
            end
            BK_LIN_WAIT: begin
                if (div_done) begin
                    r_lin <= div_q;
                end
            end
            BK_ANG_WAIT: begin
                if (div_done) begin
                    r_ang <= div_q;
                end
            end
            BK_DONE: begin
                if (can_load) begin
                    r_out.pos_x       <= r_x;
                    r_out.pos_y       <= r_y;
                    r_out.heading     <= r_heading;
                    r_out.quat_z      <= r_qz;
                    r_out.quat_w      <= r_qw;
                    r_out.lin_speed   <= r_lin;
                    r_out.ang_speed   <= r_ang;
                    r_out.speed_valid <= r_job.dt_pos;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.pos_x       = r_out.pos_x;
    assign o_out.pos_y       = r_out.pos_y;
    assign o_out.heading     = r_out.heading;
    assign o_out.quat_z      = r_out.quat_z;
    assign o_out.quat_w      = r_out.quat_w;
    assign o_out.lin_speed   = r_out.lin_speed;
    assign o_out.ang_speed   = r_out.ang_speed;
    assign o_out.speed_valid = r_out.speed_valid;

endmodule

// ===== hdl/diff_drive_odometry_unit.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry_unit
// Differential-drive wheel odometry with a register port for the two gains.
//
// Samples (time stamp, left and right wheel angle) enter on i_in; each sample
// gives one pose transaction on o_out: x, y, heading, yaw quaternion, speeds.
// The front end takes a sample in the cycle it is offered as long as the
// two-entry job queue has room, so up to two samples wait behind the one in
// work. The back end handles one job at a time; its run time is set by the
// two 80-step speed divisions, made only when the time step is positive,
// and the two 24-step runs of the shared CORDIC. A finished result sits in
// the output register; the back end stalls only when a second result is
// ready and the receiver still holds off. Reset clears the previous sample,
// the pose and the queue and loads the default gains. The user must write
// gains through the APB port only while the block is idle, which the block
// does not enforce; linear_gain is at address 0 and angular_gain at address 4.
// ----------------------------------------------------------------------------
module diff_drive_odometry_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ddodo_in_if.sink    i_in,
    ddodo_out_if.source o_out
);
    import ddodo_pkg::*;

    logic [31:0] r_linear_gain;
    logic [31:0] r_angular_gain;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_job        job_in;
    t_job        job_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ANGULAR_GAIN) ? r_angular_gain : r_linear_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear_gain  <= LINEAR_GAIN_RESET;
            r_angular_gain <= ANGULAR_GAIN_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_LINEAR_GAIN) begin
                r_linear_gain <= pwdata;
            end else begin
                r_angular_gain <= pwdata;
            end
        end
    end

    ddodo_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in)
    );

    ddodo_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (job_out)
    );

    ddodo_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_job          (job_out),
        .o_pop          (pop),
        .i_linear_gain  (r_linear_gain),
        .i_angular_gain (r_angular_gain),
        .o_out          (o_out)
    );

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.heading < 32'sd1686629713) && (o_out.heading > -32'sd1686629713))
        else $error("Heading left the open range of plus or minus two pi.");

    a_speed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.speed_valid) |-> (o_out.lin_speed == 0) && (o_out.ang_speed == 0))
        else $error("Speeds are not zero for a non-positive time step.");

    a_quat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.quat_z <= 32'sd1073741824) && (o_out.quat_z >= -32'sd1073741824)
                     && (o_out.quat_w <= 32'sd1073741824) && (o_out.quat_w >= -32'sd1073741824))
        else $error("Quaternion component outside the unit range.");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !push)
        else $error("Job pushed into a full queue.");

endmodule
